[rtl/core/tmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared constants, operation codes and the result struct of the text console.
// ----------------------------------------------------------------------------
package tmc_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int POS_W       = 11;

	localparam logic [15:0] BLANK_CELL = 16'h0720;
	localparam logic [7:0]  SPACE_CHAR = 8'h20;

	// operation codes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_SET   = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// control characters
	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NL  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             is_read;
		logic             scrolled;
	} res_t;

endpackage

[rtl/core/tmc_cell_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_cell_ram
// Cell store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tmc_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/tmc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_ctrl
// Cursor registers and the sequencer that drives the cell store: put, clear
// sweep, scroll copy, blank row, cell read and the reset clearing pass.
// ----------------------------------------------------------------------------
module tmc_ctrl import tmc_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	parameter int CELLS   = COLUMNS * ROWS,
	parameter int AW      = $clog2(CELLS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_op,
	input  logic [7:0]    in_char,
	input  logic [7:0]    in_attr,
	input  logic [7:0]    in_col,
	input  logic [7:0]    in_row,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [15:0]   wr_data,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  logic [15:0]   rd_data,
	output logic          res_valid,
	output res_t          res,
	input  logic          res_ready
);

	localparam int CW   = $clog2(COLUMNS);
	localparam int RW   = $clog2(ROWS);
	localparam int MOVE = COLUMNS * (ROWS - 1);
	localparam int PW   = (AW > POS_W) ? AW : POS_W;

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_FILL   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_BLANK  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]    state_q;
	logic [AW-1:0] cnt_q;
	logic [15:0]   fill_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          is_read_q;
	logic          scrolled_q;

	logic          accept;
	logic          printable;
	logic          overflow;
	logic [CW:0]   nc;
	logic [RW:0]   nr;
	logic [CW-1:0] set_col;
	logic [RW-1:0] set_row;
	logic [PW-1:0] cur_lin;
	logic [PW-1:0] read_lin;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign set_col = (in_col > 8'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : in_col[CW-1:0];
	assign set_row = (in_row > 8'(ROWS - 1)) ? RW'(ROWS - 1) : in_row[RW-1:0];

	assign cur_lin  = PW'(row_q) * PW'(COLUMNS) + PW'(col_q);
	assign read_lin = PW'(set_row) * PW'(COLUMNS) + PW'(set_col);

	// next cursor for put character
	always_comb begin
		nc        = {1'b0, col_q};
		nr        = {1'b0, row_q};
		printable = 1'b0;
		unique case (in_char)
			CH_NL: begin
				nc = '0;
				nr = {1'b0, row_q} + (RW+1)'(1);
			end
			CH_CR: begin
				nc = '0;
			end
			CH_BS: begin
				if (col_q != '0) begin
					nc = {1'b0, col_q} - (CW+1)'(1);
				end
			end
			CH_TAB: begin
				nc = ({1'b0, col_q} + (CW+1)'(8)) & ~((CW+1)'(7));
			end
			default: begin
				printable = 1'b1;
				nc        = {1'b0, col_q} + (CW+1)'(1);
			end
		endcase
		if (nc >= (CW+1)'(COLUMNS)) begin
			nc = '0;
			nr = nr + (RW+1)'(1);
		end
		overflow = (nr >= (RW+1)'(ROWS));
	end

	// memory requests; operations never overlap, so no two accesses meet on one cell
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = BLANK_CELL;
		rd_en   = 1'b0;
		rd_addr = cnt_q;
		unique case (state_q)
			ST_INIT: begin
				wr_en = 1'b1;
			end
			ST_FILL: begin
				wr_en   = 1'b1;
				wr_data = fill_q;
			end
			ST_IDLE: begin
				if (accept && in_op == OP_PUT && printable) begin
					wr_en   = 1'b1;
					wr_addr = cur_lin[AW-1:0];
					wr_data = {in_attr, in_char};
				end
				if (accept && in_op == OP_READ) begin
					rd_en   = 1'b1;
					rd_addr = read_lin[AW-1:0];
				end
			end
			ST_SCROLL: begin
				// read one row below, write it back in the next cycle
				if (cnt_q != AW'(MOVE)) begin
					rd_en   = 1'b1;
					rd_addr = cnt_q + AW'(COLUMNS);
				end
				if (cnt_q != '0) begin
					wr_en   = 1'b1;
					wr_addr = cnt_q - AW'(1);
					wr_data = rd_data;
				end
			end
			ST_BLANK: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res_valid    = (state_q == ST_DONE);
	assign res.pos      = cur_lin[POS_W-1:0];
	assign res.is_read  = is_read_q;
	assign res.scrolled = scrolled_q;

	always_ff @(posedge clk) begin
		if (accept && in_op == OP_CLEAR) begin
			fill_q <= {in_attr, SPACE_CHAR};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cnt_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
			is_read_q  <= 1'b0;
			scrolled_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (cnt_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_FILL: begin
					if (cnt_q == AW'(CELLS - 1)) begin
						state_q <= ST_DONE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (in_op)
							OP_PUT: begin
								if (overflow) begin
									row_q      <= RW'(ROWS - 1);
									col_q      <= '0;
									scrolled_q <= 1'b1;
									cnt_q      <= '0;
									state_q    <= ST_SCROLL;
								end else begin
									col_q   <= nc[CW-1:0];
									row_q   <= nr[RW-1:0];
									state_q <= ST_DONE;
								end
							end
							OP_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							OP_SET: begin
								col_q   <= set_col;
								row_q   <= set_row;
								state_q <= ST_DONE;
							end
							OP_READ: begin
								is_read_q <= 1'b1;
								state_q   <= ST_DONE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCROLL: begin
					// last copy write leaves cnt at the first cell of the last row
					if (cnt_q == AW'(MOVE)) begin
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_BLANK: begin
					if (cnt_q == AW'(CELLS - 1)) begin
						state_q <= ST_DONE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q    <= ST_IDLE;
						is_read_q  <= 1'b0;
						scrolled_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/text_mode_console.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console
// Character-cell text console with cursor, scroll and cell read-back.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser selects the operation (put
// character, clear screen, set cursor, read cell), s_tdata carries the
// character, attribute, column and row. Each request gives one response on
// the m_ channel with the cursor position after the operation, the cell read
// back (zero unless a read) and a scrolled flag.
// A put that scrolls copies the rows up by one through the cell store and then
// blanks the last row; a clear writes a space in the given attribute into every
// cell. Those walks are set by the single write port of the cell memory.
// After reset a clearing pass writes 0x0720 into every cell (2000 at 80x25),
// with s_tready low throughout.
// The response sits in an output register; while the receiver stalls, the
// next request is still taken and runs, and its response waits inside until
// the register frees up.
// ----------------------------------------------------------------------------
module text_mode_console import tmc_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_code, attribute, column, row_number
	input  logic [1:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // cursor_position, cell_value, scrolled, zero pad
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [15:0]   rd_data;
	logic          res_valid;
	res_t          res;
	logic          out_free;
	logic          m_tvalid_q;
	logic [31:0]   m_tdata_q;

	assign out_free = !m_tvalid_q || m_tready;

	tmc_ctrl #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.CELLS  (CELLS),
		.AW     (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_char  (s_tdata[7:0]),
		.in_attr  (s_tdata[15:8]),
		.in_col   (s_tdata[23:16]),
		.in_row   (s_tdata[31:24]),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(out_free)
	);

	tmc_cell_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			m_tdata_q <= {4'b0, res.scrolled, (res.is_read ? rd_data : 16'h0000), res.pos};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/core/tmc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_checker
// Port-level checks of the text console response channel.
// ----------------------------------------------------------------------------
module tmc_port_checker import tmc_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam logic [POS_W-1:0] LAST_ROW_POS = POS_W'((ROWS - 1) * COLUMNS);

	// stalled response holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("response changed while stalled");

	// cursor stays on the screen
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CELLS > 2048) || (32'(m_tdata[10:0]) < 32'(CELLS)))
		else $error("cursor position off screen");

	// a scroll leaves the cursor at the start of the last row
	a_scroll_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[27] |-> m_tdata[10:0] == LAST_ROW_POS)
		else $error("scroll left cursor off the last row start");

	// only a put scrolls, and a put returns no cell
	a_scroll_cell: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[27] |-> m_tdata[26:11] == 16'h0000)
		else $error("scrolled response carries a cell value");

endmodule

bind text_mode_console tmc_port_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tmc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
